// ===== hw/rtl/gcm_pkg.sv =====
package gcm_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int NUM_DENOMS = 8;
  localparam int VAL_W      = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CFG_IDX_W  = SLOT_W + 1;
  localparam int CNT_W      = $clog2(NUM_DENOMS + 1);
  localparam int STEP_W     = $clog2(VAL_W);

  typedef logic [VAL_W-1:0] val_t;

  localparam val_t DENOM_RESET [SLOT_COUNT] = '{
    16'd1, 16'd2, 16'd5, 16'd10, 16'd20, 16'd50, 16'd100, 16'd500
  };

  // One slot of the sorting chain: a coin value and its occupancy.
  typedef struct packed {
    logic v;
    val_t val;
  } cell_t;

  // Chain control from the sequencer.
  typedef struct packed {
    logic clear;
    logic shift;
  } chain_ctrl_t;

endpackage

// ===== hw/rtl/gcm_cell.sv =====
module gcm_cell (
  input  logic                clk,
  input  logic                rst,
  input  gcm_pkg::chain_ctrl_t ctrl,
  input  gcm_pkg::cell_t      ins,
  input  gcm_pkg::cell_t      nbr,
  output gcm_pkg::cell_t      held,
  output gcm_pkg::cell_t      pass
);
  import gcm_pkg::*;

  // Keep the largest value seen, hand the smaller one down the chain; on a shift, take the next cell's value.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      held.v <= 1'b0;
      pass.v <= 1'b0;
    end else if (ctrl.shift) begin
      held   <= nbr;
      pass.v <= 1'b0;
    end else if (ins.v) begin
      if (!held.v) begin
        held   <= ins;
        pass.v <= 1'b0;
      end else if (ins.val > held.val) begin
        held <= ins;
        pass <= held;
      end else begin
        pass <= ins;
      end
    end else begin
      pass.v <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/gcm_divider.sv =====
module gcm_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gcm_pkg::val_t dividend,
  input  gcm_pkg::val_t divisor,
  output logic          done,
  output gcm_pkg::val_t quot,
  output gcm_pkg::val_t rem
);
  import gcm_pkg::*;

  logic              run;
  logic [STEP_W-1:0] step;
  val_t              dvs;
  logic [VAL_W:0]    shifted;
  logic [VAL_W:0]    trial;

  assign shifted = {rem, quot[VAL_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == STEP_W'(VAL_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (run) begin
      if (!trial[VAL_W]) begin
        rem  <= trial[VAL_W-1:0];
        quot <= {quot[VAL_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[VAL_W-1:0];
        quot <= {quot[VAL_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/greedy_change_maker.sv =====
// Channel   Handshake                      Payload
// -------   ---------------------------    -----------------------------------------
// command   start / busy                   amount
// config    cfg_valid / cfg_ready          cfg_index, cfg_data
// result    result_valid (one-cycle pulse) denomination, coin_count, is_last, shortfall
//
// For each amount the block loads the coin values into a chain of sorting cells,
// lets the chain settle, then runs one restoring divide per sorted value, each ending
// in a result word; with no value in use it sends one word with the whole amount unpaid.
// One shared bit-serial divider serves every coin value in turn.
// Reset restores the default coin values [1,2,5,10,20,50,100,500] and idles the block.
// Results cannot be stalled: each word shows for exactly one cycle.
module greedy_change_maker (
  input  logic                           clk,
  input  logic                           rst,
  // command
  input  logic                           start,
  output logic                           busy,
  input  gcm_pkg::val_t                  amount,
  // config
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  gcm_pkg::val_t                  cfg_data,
  // result
  output logic                           result_valid,
  output gcm_pkg::val_t                  denomination,
  output gcm_pkg::val_t                  coin_count,
  output logic                           is_last,
  output gcm_pkg::val_t                  shortfall
);
  import gcm_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FEED   = 3'd1;
  localparam logic [2:0] ST_SETTLE = 3'd2;
  localparam logic [2:0] ST_NEXT   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  val_t             denoms [SLOT_COUNT];
  val_t             remain;

  chain_ctrl_t ctrl;
  cell_t       feed;
  cell_t       held [NUM_DENOMS];
  cell_t       pass [NUM_DENOMS];
  cell_t       ins  [NUM_DENOMS];
  cell_t       nbr  [NUM_DENOMS];

  logic div_start;
  logic div_done;
  val_t div_dividend;
  val_t div_divisor;
  val_t div_quot;
  val_t div_rem;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Coin value registers; indexes past the slot list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        denoms[i] <= DENOM_RESET[i];
      end
    end else if (cfg_valid && cfg_ready && !cfg_index[CFG_IDX_W-1]) begin
      denoms[cfg_index[SLOT_W-1:0]] <= cfg_data;
    end
  end

  // Feed one active slot per cycle; an unused slot enters as an empty bubble.
  always_comb begin
    feed.val = denoms[SLOT_W'(cnt)];
    feed.v   = (state == ST_FEED) && (feed.val != '0);
  end

  // Sorting chain: cell 0 ends up with the largest value.
  for (genvar i = 0; i < NUM_DENOMS; i++) begin : g_chain
    if (i == 0) begin : g_head
      assign ins[i] = feed;
    end else begin : g_body
      assign ins[i] = pass[i-1];
    end
    if (i == NUM_DENOMS - 1) begin : g_tail
      assign nbr[i] = '0;
    end else begin : g_link
      assign nbr[i] = held[i+1];
    end
    gcm_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .ins  (ins[i]),
      .nbr  (nbr[i]),
      .held (held[i]),
      .pass (pass[i])
    );
  end

  gcm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    ctrl.clear = (state == ST_IDLE) && start;
    ctrl.shift = (state == ST_DIV) && div_done;
    div_start  = ((state == ST_NEXT) && held[0].v) ||
                 ((state == ST_DIV) && div_done && nbr[0].v);
    // A divide that starts as the previous one reports done takes the fresh
    // remainder and the value moving up into cell 0 at that same edge.
    div_dividend = (state == ST_DIV) ? div_rem : remain;
    div_divisor  = (state == ST_DIV) ? nbr[0].val : held[0].val;
  end

  // Sequencer: load, settle, then one divide per sorted coin value (none in use: report all unpaid).
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_FEED;
            cnt   <= '0;
          end
        end
        ST_FEED: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_DENOMS - 1)) begin
            state <= ST_SETTLE;
            cnt   <= '0;
          end
        end
        ST_SETTLE: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_DENOMS - 1)) begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (held[0].v) begin
            state <= ST_DIV;
          end else begin
            // No coin value in use: report the whole amount as unpaid.
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            result_valid <= 1'b1;
            if (!nbr[0].v) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result word and running remainder.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      remain <= amount;
    end else if ((state == ST_NEXT) && !held[0].v) begin
      denomination <= '0;
      coin_count   <= '0;
      is_last      <= 1'b1;
      shortfall    <= remain;
    end else if ((state == ST_DIV) && div_done) begin
      remain       <= div_rem;
      denomination <= held[0].val;
      coin_count   <= div_quot;
      is_last      <= !nbr[0].v;
      shortfall    <= nbr[0].v ? '0 : div_rem;
    end
  end

endmodule
